### hw/rtl/rlzd_pkg.sv
package rlzd_pkg;

  localparam int BYTE_W     = 8;
  localparam int HIST_DEPTH = 65536;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int CNT_W      = 7;

  // header byte: command in [7:6], count minus one in [5:0]
  localparam logic [1:0] CMD_LITERAL = 2'b11;
  localparam logic [1:0] CMD_BACKREF = 2'b10;
  localparam logic [1:0] CMD_PAIR    = 2'b01;
  localparam logic [1:0] CMD_SINGLE  = 2'b00;

  localparam logic [BYTE_W-1:0] HDR_END = 8'h00;

  typedef struct packed {
    logic               wr_en;
    logic [HIST_AW-1:0] wr_addr;
    logic [BYTE_W-1:0]  wr_data;
    logic               rd_en;
    logic [HIST_AW-1:0] rd_addr;
  } hist_req_t;

endpackage

### hw/rtl/rlzd_if.sv
interface rlzd_in_if import rlzd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

interface rlzd_out_if import rlzd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] first_byte;
  logic [BYTE_W-1:0] second_byte;
  logic              pair_valid;
  logic              last_of_run;
  logic              stream_end;

  modport source (output valid, output first_byte, output second_byte, output pair_valid,
                  output last_of_run, output stream_end, input ready);
  modport sink   (input valid, input first_byte, input second_byte, input pair_valid,
                  input last_of_run, input stream_end, output ready);
endinterface

### hw/rtl/rlzd_hist.sv
module rlzd_hist import rlzd_pkg::*; (
  input  logic              clk,
  input  hist_req_t         req,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [HIST_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

### hw/rtl/rle_lz_byte_decompressor.sv
// Byte-serial decompressor for a run-length / back-reference code. One compressed
// byte is taken per input transfer; header, offset and first pair bytes give no
// result. A literal byte gives one result. A single-byte repeat gives count
// results at one per cycle while the output is not stalled; a pair repeat
// alternates its two history writes and a back reference a history read and
// a write (64 KiB history RAM, registered read). The input is not ready while
// results of the current byte are still being produced; an output register lets
// the next byte in while the last result waits. Every output byte is written into
// history at the write pointer. A zero header gives one end-of-stream result;
// later bytes are taken and ignored until reset.
module rle_lz_byte_decompressor import rlzd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rlzd_in_if.sink     in_ch,
  rlzd_out_if.source  out_ch
);

  typedef enum logic [6:0] {
    S_IN   = 7'b0000001,
    S_EMIT = 7'b0000010,
    S_PA   = 7'b0000100,
    S_PB   = 7'b0001000,
    S_RD   = 7'b0010000,
    S_WR   = 7'b0100000,
    S_END  = 7'b1000000
  } state_t;

  typedef enum logic [6:0] {
    PH_HEADER  = 7'b0000001,
    PH_LITERAL = 7'b0000010,
    PH_OFS_LO  = 7'b0000100,
    PH_OFS_HI  = 7'b0001000,
    PH_PAIR_A  = 7'b0010000,
    PH_PAIR_B  = 7'b0100000,
    PH_SINGLE  = 7'b1000000
  } phase_t;

  state_t             st_r, st_nxt;
  phase_t             ph_r, ph_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   run_r, run_nxt;
  logic [BYTE_W-1:0]  ofs_r, ofs_nxt;
  logic [BYTE_W-1:0]  held_r, held_nxt;
  logic [BYTE_W-1:0]  sec_r, sec_nxt;
  logic [HIST_AW-1:0] pos_r, pos_nxt;
  logic [HIST_AW-1:0] src_r, src_nxt;
  logic               done_r, done_nxt;

  logic               ov_r, ov_nxt;
  logic [BYTE_W-1:0]  ofirst_r, osecond_r;
  logic               opv_r, olast_r, oend_r;

  logic               load;
  logic [BYTE_W-1:0]  lo_first, lo_second;
  logic               lo_pv, lo_last, lo_end;

  logic [HIST_AW-1:0] add_a, add_b, sum;
  logic               slot_free;
  logic               last_rep;
  logic [BYTE_W-1:0]  b;
  hist_req_t          req;
  logic [BYTE_W-1:0]  rd_data;

  rlzd_hist u_hist (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign b         = in_ch.code_byte;
  assign slot_free = !ov_r || out_ch.ready;
  assign last_rep  = (run_r == CNT_W'(1));
  // shared 16-bit adder: pointer increments and offset add
  assign sum       = add_a + add_b;

  always_comb begin
    st_nxt    = st_r;
    ph_nxt    = ph_r;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    ofs_nxt   = ofs_r;
    held_nxt  = held_r;
    sec_nxt   = sec_r;
    pos_nxt   = pos_r;
    src_nxt   = src_r;
    done_nxt  = done_r;
    add_a     = pos_r;
    add_b     = HIST_AW'(1);
    req         = '0;
    req.wr_addr = pos_r;
    req.rd_addr = src_r;
    load      = 1'b0;
    lo_first  = '0;
    lo_second = '0;
    lo_pv     = 1'b0;
    lo_last   = 1'b0;
    lo_end    = 1'b0;
    in_ch.ready = (st_r == S_IN);

    unique case (st_r)
      S_IN: begin
        if (in_ch.valid && !done_r) begin
          unique case (ph_r)
            PH_HEADER: begin
              if (b == HDR_END) begin
                done_nxt = 1'b1;
                st_nxt   = S_END;
              end else begin
                cnt_nxt = CNT_W'(b[5:0]) + CNT_W'(1);
                unique case (b[7:6])
                  CMD_LITERAL: ph_nxt = PH_LITERAL;
                  CMD_BACKREF: ph_nxt = PH_OFS_LO;
                  CMD_PAIR:    ph_nxt = PH_PAIR_A;
                  CMD_SINGLE:  ph_nxt = PH_SINGLE;
                  default:     ph_nxt = PH_SINGLE;
                endcase
              end
            end
            PH_LITERAL: begin
              held_nxt = b;
              run_nxt  = CNT_W'(1);
              st_nxt   = S_EMIT;
              if (cnt_r <= CNT_W'(1)) begin
                cnt_nxt = '0;
                ph_nxt  = PH_HEADER;
              end else begin
                cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
            PH_OFS_LO: begin
              ofs_nxt = b;
              ph_nxt  = PH_OFS_HI;
            end
            PH_OFS_HI: begin
              add_a   = {b, ofs_r};
              add_b   = pos_r;
              src_nxt = sum;
              run_nxt = cnt_r;
              cnt_nxt = '0;
              ph_nxt  = PH_HEADER;
              st_nxt  = S_RD;
            end
            PH_PAIR_A: begin
              held_nxt = b;
              ph_nxt   = PH_PAIR_B;
            end
            PH_PAIR_B: begin
              sec_nxt = b;
              run_nxt = cnt_r;
              cnt_nxt = '0;
              ph_nxt  = PH_HEADER;
              st_nxt  = S_PA;
            end
            PH_SINGLE: begin
              held_nxt = b;
              run_nxt  = cnt_r;
              cnt_nxt  = '0;
              ph_nxt   = PH_HEADER;
              st_nxt   = S_EMIT;
            end
            default: begin
              ph_nxt  = PH_HEADER;
              cnt_nxt = '0;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          req.wr_en   = 1'b1;
          req.wr_data = held_r;
          pos_nxt     = sum;
          load        = 1'b1;
          lo_first    = held_r;
          lo_last     = last_rep;
          run_nxt     = run_r - CNT_W'(1);
          if (last_rep) begin
            st_nxt = S_IN;
          end
        end
      end
      S_PA: begin
        req.wr_en   = 1'b1;
        req.wr_data = held_r;
        pos_nxt     = sum;
        st_nxt      = S_PB;
      end
      S_PB: begin
        if (slot_free) begin
          req.wr_en   = 1'b1;
          req.wr_data = sec_r;
          pos_nxt     = sum;
          load        = 1'b1;
          lo_first    = held_r;
          lo_second   = sec_r;
          lo_pv       = 1'b1;
          lo_last     = last_rep;
          run_nxt     = run_r - CNT_W'(1);
          st_nxt      = last_rep ? S_IN : S_PA;
        end
      end
      S_RD: begin
        req.rd_en = 1'b1;
        add_a     = src_r;
        src_nxt   = sum;
        st_nxt    = S_WR;
      end
      S_WR: begin
        if (slot_free) begin
          req.wr_en   = 1'b1;
          req.wr_data = rd_data;
          pos_nxt     = sum;
          load        = 1'b1;
          lo_first    = rd_data;
          lo_last     = last_rep;
          run_nxt     = run_r - CNT_W'(1);
          st_nxt      = last_rep ? S_IN : S_RD;
        end
      end
      S_END: begin
        if (slot_free) begin
          load    = 1'b1;
          lo_last = 1'b1;
          lo_end  = 1'b1;
          st_nxt  = S_IN;
        end
      end
      default: st_nxt = S_IN;
    endcase

    ov_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IN;
      ph_r   <= PH_HEADER;
      cnt_r  <= '0;
      run_r  <= '0;
      ofs_r  <= '0;
      held_r <= '0;
      sec_r  <= '0;
      pos_r  <= '0;
      src_r  <= '0;
      done_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ph_r   <= ph_nxt;
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      ofs_r  <= ofs_nxt;
      held_r <= held_nxt;
      sec_r  <= sec_nxt;
      pos_r  <= pos_nxt;
      src_r  <= src_nxt;
      done_r <= done_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ofirst_r  <= lo_first;
      osecond_r <= lo_second;
      opv_r     <= lo_pv;
      olast_r   <= lo_last;
      oend_r    <= lo_end;
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.first_byte  = ofirst_r;
  assign out_ch.second_byte = osecond_r;
  assign out_ch.pair_valid  = opv_r;
  assign out_ch.last_of_run = olast_r;
  assign out_ch.stream_end  = oend_r;

endmodule

### hw/rtl/rlzd_chk.sv
module rlzd_chk import rlzd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_first_byte,
  input logic [BYTE_W-1:0] out_second_byte,
  input logic              out_pair_valid,
  input logic              out_last_of_run,
  input logic              out_stream_end
);

  logic seen_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_end_r <= 1'b0;
    end else if (out_valid && out_ready && out_stream_end) begin
      seen_end_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_first_byte)
      && $stable(out_second_byte) && $stable(out_pair_valid)
      && $stable(out_last_of_run) && $stable(out_stream_end))
    else $error("result changed while stalled");

  a_end_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_end |-> out_last_of_run && !out_pair_valid
      && out_first_byte == '0 && out_second_byte == '0)
    else $error("malformed end-of-stream result");

  a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pair_valid |-> out_second_byte == '0)
    else $error("second byte set without pair");

  a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    seen_end_r |-> !out_valid)
    else $error("result after end of stream");

endmodule

bind rle_lz_byte_decompressor rlzd_chk u_rlzd_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_first_byte  (out_ch.first_byte),
  .out_second_byte (out_ch.second_byte),
  .out_pair_valid  (out_ch.pair_valid),
  .out_last_of_run (out_ch.last_of_run),
  .out_stream_end  (out_ch.stream_end)
);
